>>> sv/mat_pkg.sv
// ============================================================================
// Moving-average threshold package
// Fixed field widths, register indexes, reset values and the configuration
// type shared by the front part, the back part and the top level.
// ============================================================================
package mat_pkg;

    localparam int CMP_W       = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENOMINATOR = 1'b1;

    localparam logic [CFG_W-1:0] NUMERATOR_RESET   = 16'd2;
    localparam logic [CFG_W-1:0] DENOMINATOR_RESET = 16'd100;

    typedef struct packed {
        logic [CFG_W-1:0] numerator;
        logic [CFG_W-1:0] denominator;
    } cfg_t;

endpackage

>>> sv/mat_ifs.sv
// ============================================================================
// Moving-average threshold channels
// Valid/ready channels for samples, results and configuration writes.
// ============================================================================
interface mat_in_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic [SAMPLE_WIDTH-1:0]        new_sample;
    logic [mat_pkg::CMP_W-1:0]      compare_value;

    modport source (output valid, output new_sample, output compare_value, input ready);
    modport sink   (input valid, input new_sample, input compare_value, output ready);
endinterface

interface mat_out_if #(
    parameter int TOTAL_W = 36,
    parameter int CNT_W   = 5
);
    logic                valid;
    logic                ready;
    logic [TOTAL_W-1:0]  window_total;
    logic [CNT_W-1:0]    samples_held;
    logic                window_full;
    logic                above_margin;

    modport source (output valid, output window_total, output samples_held,
                    output window_full, output above_margin, input ready);
    modport sink   (input valid, input window_total, input samples_held,
                    input window_full, input above_margin, output ready);
endinterface

interface mat_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mat_pkg::CFG_IDX_W-1:0]    index;
    logic [mat_pkg::CFG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/mat_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module mat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> sv/mat_fifo.sv
// ============================================================================
// Moving-average threshold queue
// Short first-in first-out queue that decouples the front and back parts.
// ============================================================================
module mat_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic [WIDTH-1:0]  slot_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != (ADDR_W+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + ADDR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + ADDR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (ADDR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (ADDR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/mat_front.sv
// ============================================================================
// Moving-average threshold front part
// Accepts samples, keeps the ring, running sum, write slot and fill level,
// and queues the updated window state with the compare value.
// ============================================================================
module mat_front #(
    parameter int WINDOW_SIZE  = 16,
    parameter int SAMPLE_WIDTH = 32,
    parameter int TOTAL_W      = SAMPLE_WIDTH + $clog2(WINDOW_SIZE),
    parameter int CNT_W        = $clog2(WINDOW_SIZE + 1),
    parameter int PUSH_W       = TOTAL_W + CNT_W + mat_pkg::CMP_W
) (
    input  logic              clk,
    input  logic              rst_n,
    mat_in_if.sink            sample,
    output logic              push_valid,
    input  logic              push_ready,
    output logic [PUSH_W-1:0] push_data
);

    localparam int SLOT_W = $clog2(WINDOW_SIZE);

    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [SAMPLE_WIDTH-1:0]   leaving;
    logic signed [TOTAL_W-1:0] drop, add;
    logic                      full_now;
    logic                      accept;

    assign accept       = sample.valid && push_ready;
    assign sample.ready = push_ready;
    assign push_valid   = sample.valid;
    assign full_now     = (fill_reg == CNT_W'(WINDOW_SIZE));

    // The RAM is read at the slot that the next sample will overwrite, so the
    // leaving sample is already waiting when that sample arrives.
    mat_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (WINDOW_SIZE)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (slot_reg),
        .wdata (sample.new_sample),
        .raddr (slot_next),
        .rdata (leaving)
    );

    always_comb
    begin
        add        = TOTAL_W'($signed(sample.new_sample));
        drop       = full_now ? TOTAL_W'($signed(leaving)) : '0;
        total_next = total_reg;
        slot_next  = slot_reg;
        fill_next  = fill_reg;
        if (accept)
        begin
            total_next = total_reg - drop + add;
            slot_next  = slot_reg + SLOT_W'(1);
            if (!full_now)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    assign push_data = {total_next, fill_next, sample.compare_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            slot_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            total_reg <= total_next;
            slot_reg  <= slot_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

>>> sv/mat_back.sv
// ============================================================================
// Moving-average threshold back part
// Takes queued window state, forms both cross products in two multiply
// stages and holds the finished result in the output register.
// ============================================================================
module mat_back #(
    parameter int WINDOW_SIZE  = 16,
    parameter int SAMPLE_WIDTH = 32,
    parameter int TOTAL_W      = SAMPLE_WIDTH + $clog2(WINDOW_SIZE),
    parameter int CNT_W        = $clog2(WINDOW_SIZE + 1),
    parameter int PUSH_W       = TOTAL_W + CNT_W + mat_pkg::CMP_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mat_pkg::cfg_t     cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  logic [PUSH_W-1:0] pop_data,
    mat_out_if.source         result
);

    localparam int A_W     = mat_pkg::CMP_W + CNT_W + 1;
    localparam int LHS_W   = A_W + mat_pkg::CFG_W + 1;
    localparam int RHS_W   = TOTAL_W + mat_pkg::CFG_W + 2;
    localparam int PROD_W  = ((LHS_W > RHS_W) ? LHS_W : RHS_W) + 1;

    logic signed [TOTAL_W-1:0]        q_total;
    logic [CNT_W-1:0]                 q_fill;
    logic signed [mat_pkg::CMP_W-1:0] q_cmp;
    logic [mat_pkg::CFG_W:0]          margin_sum;
    logic                             advance;

    logic                      a_valid_reg;
    logic signed [A_W-1:0]     a_prod_reg, a_prod_next;
    logic signed [TOTAL_W-1:0] a_total_reg;
    logic [CNT_W-1:0]          a_fill_reg;

    logic                      b_valid_reg;
    logic signed [PROD_W-1:0]  b_lhs_reg, b_lhs_next;
    logic signed [PROD_W-1:0]  b_rhs_reg, b_rhs_next;
    logic signed [TOTAL_W-1:0] b_total_reg;
    logic [CNT_W-1:0]          b_fill_reg;

    logic                      out_valid_reg;
    logic [TOTAL_W-1:0]        out_total_reg;
    logic [CNT_W-1:0]          out_fill_reg;
    logic                      out_full_reg;
    logic                      out_above_reg;

    assign q_total = pop_data[PUSH_W-1 -: TOTAL_W];
    assign q_fill  = pop_data[mat_pkg::CMP_W +: CNT_W];
    assign q_cmp   = pop_data[mat_pkg::CMP_W-1:0];

    // The whole pipeline moves together; it only halts while a finished
    // result waits for its transfer.
    assign advance   = !out_valid_reg || result.ready;
    assign pop_ready = advance;

    assign margin_sum = {1'b0, cfg.denominator} + {1'b0, cfg.numerator};

    always_comb
    begin
        a_prod_next = A_W'(q_cmp) * A_W'($signed({1'b0, q_fill}));
        b_lhs_next  = PROD_W'(a_prod_reg) * PROD_W'($signed({1'b0, cfg.denominator}));
        b_rhs_next  = PROD_W'(a_total_reg) * PROD_W'($signed({1'b0, margin_sum}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= pop_valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_prod_reg    <= a_prod_next;
            a_total_reg   <= q_total;
            a_fill_reg    <= q_fill;
            b_lhs_reg     <= b_lhs_next;
            b_rhs_reg     <= b_rhs_next;
            b_total_reg   <= a_total_reg;
            b_fill_reg    <= a_fill_reg;
            out_total_reg <= b_total_reg;
            out_fill_reg  <= b_fill_reg;
            out_full_reg  <= (b_fill_reg == CNT_W'(WINDOW_SIZE));
            out_above_reg <= (b_lhs_reg > b_rhs_reg);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.window_total = out_total_reg;
    assign result.samples_held = out_fill_reg;
    assign result.window_full  = out_full_reg;
    assign result.above_margin = out_above_reg;

endmodule

>>> sv/moving_average_threshold_core.sv
// ============================================================================
// Moving-average threshold core
// Running sum over a sliding window of samples with a margin test.
// ============================================================================
// Each transfer on the sample channel pushes one signed sample into a
// ring of WINDOW_SIZE entries together with a compare value. For every
// sample one transfer appears on the result channel, in order: the sum of
// the window, the number of samples held, a full flag and whether the
// compare value lies above the average scaled by (1 + numerator/denominator).
// The two margin registers are written over the configuration channel,
// which is always ready; write them only while no sample is in flight.
// A result passes from the four-entry queue through two pipelined multiply
// stages into the output register. One sample is taken every cycle while
// the queue has room; the single add of the running sum sets that rate.
// When the receiver stalls, the result is held, the back pipeline halts
// and the queue fills; sample ready falls once the queue is full.
// Reset empties the window, clears the sum and restores the margin to
// 2/100. Ring contents are not cleared; a slot is only used once written.
// ============================================================================
module moving_average_threshold_core #(
    parameter int WINDOW_SIZE  = 16,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    mat_cfg_if.sink   cfg,
    mat_in_if.sink    sample,
    mat_out_if.source result
);

    localparam int TOTAL_W = SAMPLE_WIDTH + $clog2(WINDOW_SIZE);
    localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
    localparam int PUSH_W  = TOTAL_W + CNT_W + mat_pkg::CMP_W;

    mat_pkg::cfg_t     cfg_reg, cfg_next;
    logic              push_valid, push_ready;
    logic [PUSH_W-1:0] push_data;
    logic              pop_valid, pop_ready;
    logic [PUSH_W-1:0] pop_data;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                mat_pkg::CFG_NUMERATOR:   cfg_next.numerator   = cfg.data;
                mat_pkg::CFG_DENOMINATOR: cfg_next.denominator = cfg.data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.numerator   <= mat_pkg::NUMERATOR_RESET;
            cfg_reg.denominator <= mat_pkg::DENOMINATOR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mat_front #(
        .WINDOW_SIZE  (WINDOW_SIZE),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TOTAL_W      (TOTAL_W),
        .CNT_W        (CNT_W),
        .PUSH_W       (PUSH_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mat_fifo #(
        .WIDTH (PUSH_W),
        .DEPTH (mat_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mat_back #(
        .WINDOW_SIZE  (WINDOW_SIZE),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TOTAL_W      (TOTAL_W),
        .CNT_W        (CNT_W),
        .PUSH_W       (PUSH_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

>>> sv/mat_checker.sv
// ============================================================================
// Moving-average threshold checker
// Port-level assertions on the result channel, bound to the top level.
// ============================================================================
module mat_checker #(
    parameter int WINDOW_SIZE = 16,
    parameter int TOTAL_W     = 36,
    parameter int CNT_W       = 5
) (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [TOTAL_W-1:0] res_total,
    input logic [CNT_W-1:0]   res_held,
    input logic               res_full,
    input logic               res_above
);

    // A stalled result keeps its transfer pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_total) && $stable(res_held)
                                    && $stable(res_full) && $stable(res_above))
        else $error("stalled result changed");

    // The full flag must agree with the sample count.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_full == (res_held == CNT_W'(WINDOW_SIZE))))
        else $error("full flag disagrees with sample count");

    // Every result follows at least one sample and never exceeds the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_held != '0) && (res_held <= CNT_W'(WINDOW_SIZE)))
        else $error("sample count out of range");

endmodule

bind moving_average_threshold_core mat_checker #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .TOTAL_W     (TOTAL_W),
    .CNT_W       (CNT_W)
) u_mat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_total (result.window_total),
    .res_held  (result.samples_held),
    .res_full  (result.window_full),
    .res_above (result.above_margin)
);
